// File: rtl/mas_pkg.sv
package mas_pkg;

  // default sizing
  localparam int unsigned WindowMaxDef  = 64;
  localparam int unsigned SampleBitsDef = 16;

  // width of the window length config input
  localparam int unsigned CfgBits = 7;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: rtl/mas_delay_ram.sv
module mas_delay_ram #(
  parameter int unsigned DEPTH = mas_pkg::WindowMaxDef,
  parameter int unsigned WIDTH = mas_pkg::SampleBitsDef,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic signed [WIDTH-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [AW-1:0]           raddr_i,
  output logic signed [WIDTH-1:0] rdata_o
);

  logic signed [WIDTH-1:0] mem_q [DEPTH];
  logic signed [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mas_divider.sv
module mas_divider #(
  parameter int unsigned DW = 22,  // dividend width, signed
  parameter int unsigned VW = 7,   // divisor width, unsigned
  parameter int unsigned QW = 16   // quotient width kept
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [DW-1:0]      dividend_i,
  input  logic [VW-1:0]             divisor_i,
  output mas_pkg::div_status_t      status_o,
  output logic signed [QW-1:0]      quotient_o
);

  import mas_pkg::*;

  localparam int unsigned CntW = $clog2(DW + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [VW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   quo_q;
  logic [VW-1:0]   dvs_q;
  logic            neg_q;
  logic [VW:0]     trial;
  logic            ge;
  logic [DW-1:0]   mag;
  logic [QW-1:0]   q_lo;

  // one restoring step: shift in next dividend bit, try a subtract
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
    mag   = dividend_i[DW-1] ? DW'(-dividend_i) : DW'(dividend_i);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // datapath: magnitude in, quotient bits shift in from the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag;
      rem_q <= '0;
      dvs_q <= divisor_i;
      neg_q <= dividend_i[DW-1];
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  // restore sign, truncation toward zero falls out of magnitude division
  assign q_lo       = quo_q[QW-1:0];
  assign quotient_o = neg_q ? $signed(-q_lo) : $signed(q_lo);

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// File: rtl/moving_average_smoother.sv
// Boxcar moving average over a delay-line RAM with a running sum.
// Per sample: capture the beat and read the oldest slot, write the RAM and update
//   the sum (S_SUM), start the bit-serial divider when an average is due (S_LOAD),
//   then wait for it and load the output register (S_DIV). One sample at a time:
//   in_stall_o stays high until the sequencer is back in S_IDLE.
// Reset: window length 1, sum, fill count and write pointer cleared; RAM not cleared.
module moving_average_smoother #(
  parameter int unsigned WINDOW_MAX  = mas_pkg::WindowMaxDef,
  parameter int unsigned SAMPLE_BITS = mas_pkg::SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [mas_pkg::CfgBits-1:0]   cfg_window_length_i,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic                          last_sample_i,
  // average channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] average_out_o
);

  import mas_pkg::*;

  localparam int unsigned AddrW = $clog2(WINDOW_MAX);
  localparam int unsigned LenW  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SumW  = SAMPLE_BITS + $clog2(WINDOW_MAX);

  localparam logic [AddrW:0]   WinMaxA = (AddrW + 1)'(WINDOW_MAX);
  localparam logic [LenW-1:0]  WinMaxL = LenW'(WINDOW_MAX);
  localparam logic [AddrW-1:0] WpLast  = AddrW'(WINDOW_MAX - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_LOAD = 4'b0100,
    S_DIV  = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [LenW-1:0]         len_q, len_d;
  logic [AddrW-1:0]        off_q, off_d;
  logic [AddrW-1:0]        wp_q;
  logic [LenW-1:0]         fill_q, fill_d;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic                    produce_q, full;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic                    last_q;
  logic                    out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_data_q;

  logic                    in_beat, out_beat, out_load;
  logic [AddrW:0]          old_sum;
  logic [AddrW-1:0]        old_addr;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic                    div_start;
  div_status_t             div_stat;
  logic signed [SAMPLE_BITS-1:0] div_quot;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_q && !out_stall_i;

  // effective window length and its ring offset, settled at config time
  always_comb begin
    if (cfg_window_length_i == '0) begin
      len_d = LenW'(1);
    end else if (32'(cfg_window_length_i) > WINDOW_MAX) begin
      len_d = WinMaxL;
    end else begin
      len_d = LenW'(cfg_window_length_i);
    end
    off_d = AddrW'(WinMaxL - len_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(1);
      off_q <= WpLast;
    end else if (cfg_we_i) begin
      len_q <= len_d;
      off_q <= off_d;
    end
  end

  // oldest slot: write pointer minus length, modulo the ring size
  always_comb begin
    old_sum  = {1'b0, wp_q} + {1'b0, off_q};
    old_addr = (old_sum >= WinMaxA) ? AddrW'(old_sum - WinMaxA) : old_sum[AddrW-1:0];
  end

  mas_delay_ram #(
    .DEPTH (WINDOW_MAX),
    .WIDTH (SAMPLE_BITS),
    .AW    (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_SUM),
    .waddr_i (wp_q),
    .wdata_i (x_q),
    .re_i    (in_beat),
    .raddr_i (old_addr),
    .rdata_o (rd_data)
  );

  // running sum update: drop oldest once full, add newest
  always_comb begin
    full   = fill_q >= len_q;
    fill_d = full ? fill_q : fill_q + 1'b1;
    sum_d  = sum_q - (full ? SumW'(rd_data) : '0) + SumW'(x_q);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_beat) state_d = S_SUM;
      S_SUM:   state_d = S_LOAD;
      S_LOAD:  state_d = produce_q ? S_DIV : S_IDLE;
      S_DIV:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign div_start = (state_q == S_LOAD) && produce_q;
  assign out_load  = (state_q == S_DIV) && div_stat.done && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wp_q      <= '0;
      fill_q    <= '0;
      sum_q     <= '0;
      produce_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        fill_q <= '0;
        sum_q  <= '0;
      end else if (state_q == S_SUM) begin
        fill_q    <= fill_d;
        sum_q     <= sum_d;
        produce_q <= fill_d >= len_q;
        wp_q      <= (wp_q == WpLast) ? '0 : wp_q + 1'b1;
      end else if ((state_q == S_LOAD) && last_q) begin
        // end of record: divider has already taken the sum
        fill_q <= '0;
        sum_q  <= '0;
      end
    end
  end

  // captured sample beat
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      x_q    <= sample_in_i;
      last_q <= last_sample_i;
    end
  end

  mas_divider #(
    .DW (SumW),
    .VW (LenW),
    .QW (SAMPLE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (len_q),
    .status_o   (div_stat),
    .quotient_o (div_quot)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_beat) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= div_quot;
    end
  end

  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = out_valid_q;
  assign average_out_o = out_data_q;

  // checks
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= len_q)
    else $error("fill count above window length");

  a_out_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DIV))
    else $error("average appeared without a division");

  a_div_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on an idle divider");

  a_beat_to_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == S_SUM))
    else $error("sample beat not followed by sum update");

endmodule
